/* hw/rtl/hrhpf_pkg.sv */
package hrhpf_pkg;

	// Payload widths
	localparam int KEY_W     = 8;
	localparam int PASSKEY_W = 20;
	localparam int DIGIT_W   = 4;
	localparam int NUM_KEYS  = 6;
	localparam int NUM_DIG   = 6;

	// Request codes
	localparam logic [1:0] REQ_REPORT     = 2'd0;
	localparam logic [1:0] REQ_PAIR_START = 2'd1;
	localparam logic [1:0] REQ_PAIR_DONE  = 2'd2;
	localparam logic [1:0] REQ_LINK_UP    = 2'd3;

	// Action codes
	localparam logic [2:0] ACT_FORWARD = 3'd0;
	localparam logic [2:0] ACT_SWITCH  = 3'd1;
	localparam logic [2:0] ACT_UNPAIR  = 3'd2;
	localparam logic [2:0] ACT_SUBMIT  = 3'd3;
	localparam logic [2:0] ACT_CANCEL  = 3'd4;

	// HID usage codes
	localparam logic [7:0] K_1         = 8'h1E;
	localparam logic [7:0] K_2         = 8'h1F;
	localparam logic [7:0] K_3         = 8'h20;
	localparam logic [7:0] K_9         = 8'h26;
	localparam logic [7:0] K_0         = 8'h27;
	localparam logic [7:0] K_ENTER     = 8'h28;
	localparam logic [7:0] K_ESC       = 8'h29;
	localparam logic [7:0] K_SCROLL    = 8'h47;
	localparam logic [7:0] K_PAD_ENTER = 8'h58;

	// Control of the shared decimal accumulator
	typedef struct packed {
		logic               clr;
		logic               step;
		logic [DIGIT_W-1:0] digit;
	} acc_ctl_t;

endpackage

/* hw/rtl/hrhpf_dec_acc.sv */
// Shared decimal accumulator: clr zeroes it, else acc <= acc * 10 + digit, one digit per step
module hrhpf_dec_acc (
	input  logic                               clk,
	input  logic                               arst_n,
	input  hrhpf_pkg::acc_ctl_t                ctl,
	output logic [hrhpf_pkg::PASSKEY_W-1:0]    acc
);

	logic [hrhpf_pkg::PASSKEY_W-1:0] acc_q;
	logic [hrhpf_pkg::PASSKEY_W-1:0] times10;

	// x10 as shift-add
	assign times10 = (acc_q << 3) + (acc_q << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.step) begin
			acc_q <= times10 + hrhpf_pkg::PASSKEY_W'(ctl.digit);
		end
	end

	assign acc = acc_q;

endmodule

/* hw/rtl/hid_report_hotkey_passkey_filter.sv */
// HID report hotkey and passkey filter.
// Input channel (in_valid/in_stall) carries one word: a boot keyboard report
// or a link/pairing event. Output channel (out_valid/out_stall) carries result
// words; last marks the final word caused by one input word. Events and
// reports that give no result produce no output word.
// The user writes the current slot register through cfg_we/cfg_wdata only
// while idle; the block does not enforce this. An event is handled when it is
// accepted. A report first goes through the hotkey check, then builds the
// forward word outside pairing mode, or in pairing mode scans each key slot
// (KEY_SLOTS) and, for each passkey submit, clears and then runs six steps of
// the shared x10-add unit; then it flushes the last result; a switch request
// goes straight to the flush. in_stall is high for the whole of that time: one
// word is in flight at a time. A plain forward goes to the hold register and
// leaves via the output register at the flush. Results pass through a one-word
// hold register and an output register, so the last result carries its last
// flag. A stalled receiver holds the output register; the sequencer waits only
// when it must move a new result out. Reset clears the slot register, pairing
// mode, digit window, previous keys and the switch and unpair latches.
module hid_report_hotkey_passkey_filter #(
	parameter int KEY_SLOTS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  modifier,
	input  logic [7:0]  key0,
	input  logic [7:0]  key1,
	input  logic [7:0]  key2,
	input  logic [7:0]  key3,
	input  logic [7:0]  key4,
	input  logic [7:0]  key5,
	input  logic        link_up,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [1:0]  switch_slot,
	output logic [19:0] passkey,
	output logic [7:0]  out_modifier,
	output logic [7:0]  out_key0,
	output logic [7:0]  out_key1,
	output logic [7:0]  out_key2,
	output logic [7:0]  out_key3,
	output logic [7:0]  out_key4,
	output logic [7:0]  out_key5,
	output logic        last
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_FWD    = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_PK     = 3'd4;
	localparam logic [2:0] ST_SUBMIT = 3'd5;
	localparam logic [2:0] ST_FLUSH  = 3'd6;

	localparam logic [2:0] LAST_IDX = 3'(KEY_SLOTS - 1);
	localparam logic [2:0] LAST_DIG = 3'(hrhpf_pkg::NUM_DIG - 1);
	localparam logic [2:0] FULL_CNT = 3'(hrhpf_pkg::NUM_DIG);

	// Control state
	logic [2:0] state_q, state_d;
	logic [2:0] idx_q, idx_d;
	logic [2:0] pk_idx_q, pk_idx_d;
	logic [1:0] cur_slot_q;
	logic       pairing_q;
	logic       sw_latch_q;
	logic       unpair_q;
	logic [2:0] dig_cnt_q;
	logic       hold_v_q;
	logic       out_valid_q;

	// Latched word and stores
	logic [7:0] keys_q [hrhpf_pkg::NUM_KEYS];
	logic [7:0] prev_q [hrhpf_pkg::NUM_KEYS];
	logic [3:0] win_q  [hrhpf_pkg::NUM_DIG];
	logic [7:0] mod_q;
	logic       link_q;

	// Hold register for the newest result
	logic [2:0]  hold_action_q;
	logic [1:0]  hold_target_q;
	logic [19:0] hold_pk_q;
	logic        hold_fwd_q;

	// Output register
	logic [2:0]  out_action_q;
	logic [1:0]  out_target_q;
	logic [19:0] out_pk_q;
	logic [7:0]  out_mod_q;
	logic [7:0]  out_keys_q [hrhpf_pkg::NUM_KEYS];
	logic        out_last_q;

	logic [7:0] in_keys [hrhpf_pkg::NUM_KEYS];
	logic       accept;
	logic       out_free;

	// Sequencer outputs
	logic        hold_load, hold_clr, out_load, out_last_d;
	logic [2:0]  new_action;
	logic [1:0]  new_target;
	logic [19:0] new_pk;
	logic        new_fwd;
	logic        push_dig, prev_load, sw_set, sw_clr, pend_set, adv;
	logic [3:0]  dig_val;

	// Report decode
	logic       scroll, esc, has_num;
	logic [1:0] target;
	logic [7:0] cur_key;
	logic       seen;
	logic [7:0] dig_raw;

	hrhpf_pkg::acc_ctl_t acc_ctl;
	logic [19:0]         acc;

	hrhpf_dec_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.acc    (acc)
	);

	assign in_keys[0] = key0;
	assign in_keys[1] = key1;
	assign in_keys[2] = key2;
	assign in_keys[3] = key3;
	assign in_keys[4] = key4;
	assign in_keys[5] = key5;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Hotkey flags over the latched keys; the last number key wins
	always_comb begin
		scroll  = 1'b0;
		esc     = 1'b0;
		has_num = 1'b0;
		target  = 2'd0;
		for (int i = 0; i < hrhpf_pkg::NUM_KEYS; i++) begin
			if (keys_q[i] == hrhpf_pkg::K_SCROLL) scroll = 1'b1;
			if (keys_q[i] == hrhpf_pkg::K_ESC) esc = 1'b1;
			if (keys_q[i] == hrhpf_pkg::K_1) begin
				target = 2'd0;
				has_num = 1'b1;
			end else if (keys_q[i] == hrhpf_pkg::K_2) begin
				target = 2'd1;
				has_num = 1'b1;
			end else if (keys_q[i] == hrhpf_pkg::K_3) begin
				target = 2'd2;
				has_num = 1'b1;
			end
		end
	end

	// Key under scan and whether the previous report held it
	assign cur_key = keys_q[idx_q];
	assign dig_raw = cur_key - hrhpf_pkg::K_1 + 8'd1;
	always_comb begin
		seen = 1'b0;
		for (int j = 0; j < hrhpf_pkg::NUM_KEYS; j++) begin
			if (prev_q[j] == cur_key) seen = 1'b1;
		end
	end

	// Sequencer
	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		pk_idx_d      = pk_idx_q;
		hold_load     = 1'b0;
		hold_clr      = 1'b0;
		out_load      = 1'b0;
		out_last_d    = 1'b0;
		new_action    = hrhpf_pkg::ACT_FORWARD;
		new_target    = 2'd0;
		new_pk        = '0;
		new_fwd       = 1'b0;
		push_dig      = 1'b0;
		dig_val       = 4'd0;
		prev_load     = 1'b0;
		sw_set        = 1'b0;
		sw_clr        = 1'b0;
		pend_set      = 1'b0;
		adv           = 1'b0;
		acc_ctl.clr   = 1'b0;
		acc_ctl.step  = 1'b0;
		acc_ctl.digit = win_q[pk_idx_q];

		case (state_q)
			ST_IDLE: begin
				if (accept && req_type == hrhpf_pkg::REQ_REPORT) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (scroll && has_num && !sw_latch_q && target != cur_slot_q) begin
					sw_set     = 1'b1;
					hold_load  = 1'b1;
					new_action = hrhpf_pkg::ACT_SWITCH;
					new_target = target;
					state_d    = ST_FLUSH;
				end else begin
					sw_clr = !scroll;
					if (pairing_q) begin
						idx_d   = 3'd0;
						state_d = ST_SCAN;
					end else begin
						if (scroll && esc && !unpair_q && link_q) begin
							pend_set   = 1'b1;
							hold_load  = 1'b1;
							new_action = hrhpf_pkg::ACT_UNPAIR;
						end
						state_d = ST_FWD;
					end
				end
			end
			ST_FWD: begin
				if (!link_q) begin
					state_d = ST_FLUSH;
				end else if (!hold_v_q || out_free) begin
					hold_load  = 1'b1;
					out_load   = hold_v_q;
					new_action = hrhpf_pkg::ACT_FORWARD;
					new_fwd    = 1'b1;
					state_d    = ST_FLUSH;
				end
			end
			ST_SCAN: begin
				if (cur_key == 8'd0 || seen) begin
					adv = 1'b1;
				end else if (cur_key >= hrhpf_pkg::K_1 && cur_key <= hrhpf_pkg::K_9) begin
					push_dig = 1'b1;
					dig_val  = dig_raw[3:0];
					adv      = 1'b1;
				end else if (cur_key == hrhpf_pkg::K_0) begin
					push_dig = 1'b1;
					adv      = 1'b1;
				end else if (cur_key == hrhpf_pkg::K_ENTER
						|| cur_key == hrhpf_pkg::K_PAD_ENTER) begin
					if (dig_cnt_q == FULL_CNT) begin
						acc_ctl.clr = 1'b1;
						pk_idx_d    = 3'd0;
						state_d     = ST_PK;
					end else begin
						adv = 1'b1;
					end
				end else if (cur_key == hrhpf_pkg::K_ESC) begin
					if (!hold_v_q || out_free) begin
						hold_load  = 1'b1;
						out_load   = hold_v_q;
						new_action = hrhpf_pkg::ACT_CANCEL;
						adv        = 1'b1;
					end
				end else begin
					adv = 1'b1;
				end
			end
			ST_PK: begin
				acc_ctl.step = 1'b1;
				if (pk_idx_q == LAST_DIG) begin
					state_d = ST_SUBMIT;
				end else begin
					pk_idx_d = pk_idx_q + 3'd1;
				end
			end
			ST_SUBMIT: begin
				if (!hold_v_q || out_free) begin
					hold_load  = 1'b1;
					out_load   = hold_v_q;
					new_action = hrhpf_pkg::ACT_SUBMIT;
					new_pk     = acc;
					adv        = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (!hold_v_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					out_load   = 1'b1;
					out_last_d = 1'b1;
					hold_clr   = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Step to the next key slot, or finish the scan
		if (adv) begin
			if (idx_q == LAST_IDX) begin
				prev_load = 1'b1;
				state_d   = ST_FLUSH;
			end else begin
				idx_d   = idx_q + 3'd1;
				state_d = ST_SCAN;
			end
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= 3'd0;
			pk_idx_q    <= 3'd0;
			cur_slot_q  <= 2'd0;
			pairing_q   <= 1'b0;
			sw_latch_q  <= 1'b0;
			unpair_q    <= 1'b0;
			dig_cnt_q   <= 3'd0;
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < hrhpf_pkg::NUM_KEYS; i++) prev_q[i] <= 8'd0;
			for (int i = 0; i < hrhpf_pkg::NUM_DIG; i++) win_q[i] <= 4'd0;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			pk_idx_q <= pk_idx_d;

			if (cfg_we) cur_slot_q <= cfg_wdata;

			// Events handled at acceptance
			if (accept && (req_type == hrhpf_pkg::REQ_PAIR_START
					|| req_type == hrhpf_pkg::REQ_PAIR_DONE)) begin
				pairing_q <= (req_type == hrhpf_pkg::REQ_PAIR_START);
				dig_cnt_q <= 3'd0;
				for (int i = 0; i < hrhpf_pkg::NUM_KEYS; i++) prev_q[i] <= 8'd0;
				for (int i = 0; i < hrhpf_pkg::NUM_DIG; i++) win_q[i] <= 4'd0;
			end
			if (accept && req_type == hrhpf_pkg::REQ_LINK_UP) unpair_q <= 1'b0;

			if (sw_set) sw_latch_q <= 1'b1;
			else if (sw_clr) sw_latch_q <= 1'b0;
			if (pend_set) unpair_q <= 1'b1;

			// Digit window: shift when full, else append
			if (push_dig) begin
				if (dig_cnt_q >= FULL_CNT) begin
					for (int i = 0; i < hrhpf_pkg::NUM_DIG - 1; i++) win_q[i] <= win_q[i+1];
					win_q[hrhpf_pkg::NUM_DIG-1] <= dig_val;
				end else begin
					win_q[dig_cnt_q] <= dig_val;
					dig_cnt_q <= dig_cnt_q + 3'd1;
				end
			end

			if (prev_load) begin
				for (int i = 0; i < hrhpf_pkg::NUM_KEYS; i++) prev_q[i] <= keys_q[i];
			end

			if (hold_load) hold_v_q <= 1'b1;
			else if (hold_clr) hold_v_q <= 1'b0;

			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mod_q  <= modifier;
			link_q <= link_up;
			for (int i = 0; i < hrhpf_pkg::NUM_KEYS; i++) begin
				keys_q[i] <= (i < KEY_SLOTS) ? in_keys[i] : 8'd0;
			end
		end
		if (hold_load) begin
			hold_action_q <= new_action;
			hold_target_q <= new_target;
			hold_pk_q     <= new_pk;
			hold_fwd_q    <= new_fwd;
		end
		if (out_load) begin
			out_action_q <= hold_action_q;
			out_target_q <= hold_target_q;
			out_pk_q     <= hold_pk_q;
			out_mod_q    <= hold_fwd_q ? mod_q : 8'd0;
			for (int i = 0; i < hrhpf_pkg::NUM_KEYS; i++) begin
				out_keys_q[i] <= hold_fwd_q ? keys_q[i] : 8'd0;
			end
			out_last_q <= out_last_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign action       = out_action_q;
	assign switch_slot  = out_target_q;
	assign passkey      = out_pk_q;
	assign out_modifier = out_mod_q;
	assign out_key0     = out_keys_q[0];
	assign out_key1     = out_keys_q[1];
	assign out_key2     = out_keys_q[2];
	assign out_key3     = out_keys_q[3];
	assign out_key4     = out_keys_q[4];
	assign out_key5     = out_keys_q[5];
	assign last         = out_last_q;

endmodule
